>>> design/gvm_pkg.sv
// shared types and constants for the grid vorticity magnitude block
// no dependencies
package gvm_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_C,
    ST_CHK,
    ST_RD_LO,
    ST_RD_HI,
    ST_ACC,
    ST_SAT,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_FIN
  } gvm_state_t;

  // request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  // field widths
  localparam int COORD_W = 5;
  localparam int SIZE_W  = 6;
  localparam int CX_W    = 8;
  localparam int MAG_W   = 18;

  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;
  localparam logic [MAG_W-1:0]  MAG_MAX  = 18'd262143;

  // curl component limit, squared-length and root widths
  localparam int COMP_LIMIT = 524288;
  localparam int SQ_W       = 19;
  localparam int RAD_W      = 40;
  localparam int ROOT_W     = 20;
  localparam int CNT_W      = 5;

endpackage

>>> design/gvm_isqrt.sv
// iterative floor square root, two radicand bits per cycle
// depends on gvm_pkg
module gvm_isqrt
  import gvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              take;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial  = (ROOT_W+4)'({root_r, 2'b01});
    take   = (rem_sh >= trial);
  end

  // control
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ROOT_W - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (take) begin
        rem_r  <= (ROOT_W+2)'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= (ROOT_W+2)'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> design/grid_vorticity_magnitude.sv
// curl magnitude of a stored 3d velocity grid
// write request: taken while the sequencer is idle. query: ends early on bad coordinates or a solid cell,
// otherwise its length is set by the single read port (7 reads) and the
// 20-step square root; the next request is taken once the query leaves the sequencer
// reset (synchronous, active low): sizes back to 32, sequencer idle, grid contents kept
// depends on gvm_pkg and gvm_isqrt
module grid_vorticity_magnitude
  import gvm_pkg::*;
#(
  parameter int MAX_DIM   = 32,
  parameter int VEL_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [COORD_W-1:0]   in_cell_x,
  input  logic [COORD_W-1:0]   in_cell_y,
  input  logic [COORD_W-1:0]   in_cell_z,
  input  logic [VEL_WIDTH-1:0] in_vel_x,
  input  logic [VEL_WIDTH-1:0] in_vel_y,
  input  logic [VEL_WIDTH-1:0] in_vel_z,
  input  logic                 in_is_solid,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MAG_W-1:0]     out_magnitude,
  output logic                 out_cell_was_solid,
  output logic                 out_bad_coord,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int AW     = $clog2(MAX_DIM);
  localparam int WORD_W = 3 * VEL_WIDTH + 1;
  localparam int DEPTH  = 1 << (3 * AW);
  localparam int D_W    = VEL_WIDTH + 2;
  localparam int W_W    = VEL_WIDTH + 3;
  localparam int ABS_W  = (W_W > SQ_W + 1) ? W_W : SQ_W + 1;

  gvm_state_t state_r, state_nxt;

  logic [SIZE_W-1:0] size_r [3];
  logic [CX_W-1:0]   used [3];
  logic [CX_W-1:0]   cin [3];
  logic [CX_W-1:0]   coord_r [3];
  logic              in_acc, wr_en, bad_in;
  logic [3*AW-1:0]   wr_addr, rd_addr;
  logic              rd_en;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r, lo_r;

  logic [CX_W-1:0]   lo_c [3];
  logic [CX_W-1:0]   hi_c [3];
  logic              span2 [3];
  logic [CX_W-1:0]   nb [3];
  logic              use_hi, span_sel;
  logic [1:0]        axis_r;
  logic [1:0]        k_r;

  logic signed [VEL_WIDTH-1:0] hv [3];
  logic signed [VEL_WIDTH-1:0] lv [3];
  logic signed [VEL_WIDTH:0]   diff [3];
  logic signed [D_W-1:0]       dv [3];
  logic signed [W_W-1:0]       de [3];
  logic signed [W_W-1:0]       w_r [3];
  logic [W_W-1:0]              wa [3];
  logic [ABS_W-1:0]            wa_ext [3];
  logic                        sat;
  logic [SQ_W-1:0]             sq_sel;
  logic [2*SQ_W-1:0]           prod_r;
  logic [RAD_W-1:0]            sum_r;
  logic                        sq_start, sq_done;
  logic [ROOT_W-1:0]           sq_root;

  logic [MAG_W-1:0] mag_r;
  logic             solid_r, bad_r;
  logic             out_valid_r;
  logic [MAG_W-1:0] out_mag_r;
  logic             out_solid_r, out_bad_r;
  logic             fin_go;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0] <= SIZE_RST;
      size_r[1] <= SIZE_RST;
      size_r[2] <= SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIZE_X: size_r[0] <= cfg_data;
        CFG_SIZE_Y: size_r[1] <= cfg_data;
        CFG_SIZE_Z: size_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped sizes and request coordinates
  always_comb begin
    cin[0] = CX_W'(in_cell_x);
    cin[1] = CX_W'(in_cell_y);
    cin[2] = CX_W'(in_cell_z);
    for (int a = 0; a < 3; a++) begin
      if (size_r[a] == '0) used[a] = CX_W'(1);
      else if (CX_W'(size_r[a]) > CX_W'(MAX_DIM)) used[a] = CX_W'(MAX_DIM);
      else used[a] = CX_W'(size_r[a]);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign bad_in   = (cin[0] >= used[0]) || (cin[1] >= used[1]) || (cin[2] >= used[2]);
  assign wr_en    = in_acc && (in_op == OP_WRITE) && (cin[0] < CX_W'(MAX_DIM)) &&
                    (cin[1] < CX_W'(MAX_DIM)) && (cin[2] < CX_W'(MAX_DIM));
  assign wr_addr  = {cin[2][AW-1:0], cin[1][AW-1:0], cin[0][AW-1:0]};

  // neighbour coordinates along each axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_c[a]  = (coord_r[a] != '0) ? coord_r[a] - 1'b1 : coord_r[a];
      hi_c[a]  = (coord_r[a] + 1'b1 < used[a]) ? coord_r[a] + 1'b1 : coord_r[a];
      span2[a] = (coord_r[a] != '0) && (coord_r[a] + 1'b1 < used[a]);
    end
  end

  // neighbour on the current axis
  always_comb begin
    nb[0]    = coord_r[0];
    nb[1]    = coord_r[1];
    nb[2]    = coord_r[2];
    span_sel = 1'b0;
    unique case (axis_r)
      2'd0: begin
        nb[0]    = use_hi ? hi_c[0] : lo_c[0];
        span_sel = span2[0];
      end
      2'd1: begin
        nb[1]    = use_hi ? hi_c[1] : lo_c[1];
        span_sel = span2[1];
      end
      2'd2: begin
        nb[2]    = use_hi ? hi_c[2] : lo_c[2];
        span_sel = span2[2];
      end
      default: ;
    endcase
  end

  // read port control
  always_comb begin
    rd_en   = 1'b0;
    use_hi  = 1'b0;
    rd_addr = {coord_r[2][AW-1:0], coord_r[1][AW-1:0], coord_r[0][AW-1:0]};
    sq_start = (state_r == ST_SQRT_GO);
    unique case (state_r)
      ST_RD_C: rd_en = 1'b1;
      ST_RD_LO: begin
        rd_en   = 1'b1;
        rd_addr = {nb[2][AW-1:0], nb[1][AW-1:0], nb[0][AW-1:0]};
      end
      ST_RD_HI: begin
        rd_en   = 1'b1;
        use_hi  = 1'b1;
        rd_addr = {nb[2][AW-1:0], nb[1][AW-1:0], nb[0][AW-1:0]};
      end
      default: ;
    endcase
  end

  // cell store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {in_is_solid, in_vel_z, in_vel_y, in_vel_x};
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // differences of the three components
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hv[k]   = $signed(rd_data_r[k*VEL_WIDTH +: VEL_WIDTH]);
      lv[k]   = $signed(lo_r[k*VEL_WIDTH +: VEL_WIDTH]);
      diff[k] = {hv[k][VEL_WIDTH-1], hv[k]} - {lv[k][VEL_WIDTH-1], lv[k]};
      dv[k]   = span_sel ? {diff[k][VEL_WIDTH], diff[k]} : {diff[k], 1'b0};
      de[k]   = {dv[k][D_W-1], dv[k]};
    end
  end

  // component magnitudes and saturation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wa[k]     = w_r[k][W_W-1] ? W_W'(-w_r[k]) : W_W'(w_r[k]);
      wa_ext[k] = ABS_W'(wa[k]);
    end
    sat = (wa_ext[0] >= ABS_W'(COMP_LIMIT)) || (wa_ext[1] >= ABS_W'(COMP_LIMIT)) ||
          (wa_ext[2] >= ABS_W'(COMP_LIMIT));
    case (k_r)
      2'd0:    sq_sel = wa_ext[0][SQ_W-1:0];
      2'd1:    sq_sel = wa_ext[1][SQ_W-1:0];
      default: sq_sel = wa_ext[2][SQ_W-1:0];
    endcase
  end

  gvm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (in_acc && in_op == OP_QUERY) state_nxt = bad_in ? ST_FIN : ST_RD_C;
      ST_RD_C:      state_nxt = ST_CHK;
      ST_CHK:       state_nxt = rd_data_r[WORD_W-1] ? ST_FIN : ST_RD_LO;
      ST_RD_LO:     state_nxt = ST_RD_HI;
      ST_RD_HI:     state_nxt = ST_ACC;
      ST_ACC:       state_nxt = (axis_r == 2'd2) ? ST_SAT : ST_RD_LO;
      ST_SAT:       state_nxt = sat ? ST_FIN : ST_SQ_MUL;
      ST_SQ_MUL:    state_nxt = ST_SQ_ADD;
      ST_SQ_ADD:    state_nxt = (k_r == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sq_done) state_nxt = ST_FIN;
      ST_FIN:       if (fin_go) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) axis_r <= '0;
      else if (state_r == ST_ACC) axis_r <= axis_r + 1'b1;
      if (in_acc) k_r <= '0;
      else if (state_r == ST_SQ_ADD) k_r <= k_r + 1'b1;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_QUERY) begin
      coord_r <= cin;
      mag_r   <= '0;
      solid_r <= 1'b0;
      bad_r   <= bad_in;
      w_r[0]  <= '0;
      w_r[1]  <= '0;
      w_r[2]  <= '0;
      sum_r   <= '0;
    end
    if (state_r == ST_CHK) solid_r <= rd_data_r[WORD_W-1];
    if (state_r == ST_RD_HI) lo_r <= rd_data_r;
    // fold this axis' derivatives into the curl
    if (state_r == ST_ACC) begin
      unique case (axis_r)
        2'd0: begin
          w_r[1] <= w_r[1] - de[2];
          w_r[2] <= w_r[2] + de[1];
        end
        2'd1: begin
          w_r[0] <= w_r[0] + de[2];
          w_r[2] <= w_r[2] - de[0];
        end
        2'd2: begin
          w_r[0] <= w_r[0] - de[1];
          w_r[1] <= w_r[1] + de[0];
        end
        default: ;
      endcase
    end
    if (state_r == ST_SAT && sat) mag_r <= MAG_MAX;
    if (state_r == ST_SQ_MUL) prod_r <= sq_sel * sq_sel;
    if (state_r == ST_SQ_ADD) sum_r <= sum_r + RAD_W'(prod_r);
    if (state_r == ST_SQRT_WAIT && sq_done)
      mag_r <= sq_root[ROOT_W-1] ? MAG_MAX : sq_root[MAG_W:1];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_mag_r   <= mag_r;
      out_solid_r <= solid_r;
      out_bad_r   <= bad_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_magnitude      = out_mag_r;
  assign out_cell_was_solid = out_solid_r;
  assign out_bad_coord      = out_bad_r;

`ifndef SYNTH
  // a result appears only when the sequencer hands one over
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish state");

  // bad coordinates and solid cells carry no magnitude
  a_flag_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_bad_r || out_solid_r) |-> out_mag_r == '0)
    else $error("flagged result with nonzero magnitude");

  // bad coordinates and solid never both flagged
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_bad_r && out_solid_r))
    else $error("bad and solid flagged together");

  // the root unit only finishes while the sequencer waits for it
  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ST_SQRT_WAIT)
    else $error("square root finished unexpectedly");
`endif

endmodule
